// File: rtl/core/egbd_pkg.sv
// ----------------------------------------------------------------------------
// egbd_pkg
// Shared types and constants for the text box geometry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package egbd_pkg;

  // score map size, in cells
  localparam int unsigned MapWidth  = 256;
  localparam int unsigned MapHeight = 256;

  // pipeline depth: input, four rotation stages, multiply, sum, output
  localparam int unsigned NumStages     = 8;
  localparam int unsigned CordicStages  = 4;
  localparam int unsigned IterPerStage  = 4;
  localparam int unsigned CordicIters   = CordicStages * IterPerStage;

  // datapath widths
  localparam int unsigned XyW   = 18;
  localparam int unsigned ZW    = 20;
  localparam int unsigned AccW  = 40;
  localparam int unsigned EdgeW = 22;
  localparam int unsigned DegW  = 34;

  // fixed-point constants, radians in Q.16
  localparam logic signed [ZW-1:0]  PiQ16        = ZW'(205887);
  localparam logic signed [ZW-1:0]  HalfPiQ16    = ZW'(102944);
  localparam logic signed [XyW-1:0] CordicGainQ14 = XyW'(9949);
  localparam logic [15:0]           DegScaleQ16  = 16'd58670;
  localparam logic [15:0]           ThresholdRst = 16'd32768;

  // register map, word index
  localparam logic [0:0] RegScoreThreshold = 1'b0;

  // arctangent of 2^-i, Q.16 radians
  localparam logic [15:0] AtanQ16 [CordicIters] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
  };

  // one cell as it travels down the pipeline
  typedef struct packed {
    logic [7:0]         col;
    logic [7:0]         row;
    logic [15:0]        score;
    logic [15:0]        d_right;
    logic [15:0]        d_bottom;
    logic [16:0]        h;
    logic [16:0]        w;
    logic signed [15:0] ang;
  } cell_t;

  // rotation vector and residual angle
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } rot_t;

endpackage

`default_nettype wire

// File: rtl/core/east_geometry_box_decode.sv
// ----------------------------------------------------------------------------
// east_geometry_box_decode
// Turns one score/geometry cell into an upright pixel box, angle and score.
// ----------------------------------------------------------------------------
// A request passes through the input, rotation, multiply, sum and output registers.
// Throughput: one request per cycle; the eight-stage pipeline stalls only when
// the output register holds a result that is not taken.
// Cells below the score threshold or outside the map are taken and dropped.
// Reset empties the pipeline and sets the score threshold to 32768.
`default_nettype none

module east_geometry_box_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // cell request
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         col_i,
  input  wire logic [7:0]         row_i,
  input  wire logic [15:0]        score_i,
  input  wire logic [15:0]        dist_top_i,
  input  wire logic [15:0]        dist_right_i,
  input  wire logic [15:0]        dist_bottom_i,
  input  wire logic [15:0]        dist_left_i,
  input  wire logic signed [15:0] angle_rad_i,
  // box result
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [13:0]      box_x_o,
  output logic signed [13:0]      box_y_o,
  output logic [13:0]             box_width_o,
  output logic [13:0]             box_height_o,
  output logic signed [15:0]      angle_deg_o,
  output logic [15:0]             score_out_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned NS   = egbd_pkg::NumStages;
  localparam int unsigned CS   = egbd_pkg::CordicStages;
  localparam int unsigned XyW  = egbd_pkg::XyW;
  localparam int unsigned ZW   = egbd_pkg::ZW;
  localparam int unsigned AccW = egbd_pkg::AccW;
  localparam int unsigned EdgeW = egbd_pkg::EdgeW;
  localparam int unsigned DegW = egbd_pkg::DegW;
  localparam int unsigned StMul = CS + 1;
  localparam int unsigned StSum = CS + 2;
  localparam int unsigned StOut = CS + 3;

  // one micro-rotation of the vector toward zero residual angle
  function automatic egbd_pkg::rot_t cordic_iter(egbd_pkg::rot_t r, logic [3:0] idx);
    egbd_pkg::rot_t        n;
    logic signed [XyW-1:0] dx;
    logic signed [XyW-1:0] dy;
    logic signed [ZW-1:0]  a;
    dx = r.y >>> idx;
    dy = r.x >>> idx;
    a  = $signed(ZW'(egbd_pkg::AtanQ16[idx]));
    if (r.z >= 0) begin
      n.x = r.x - dx;
      n.y = r.y + dy;
      n.z = r.z - a;
    end else begin
      n.x = r.x + dx;
      n.y = r.y - dy;
      n.z = r.z + a;
    end
    return n;
  endfunction

  // saturate a pixel coordinate to the output range
  function automatic logic signed [13:0] sat_coord(logic signed [EdgeW-1:0] v);
    logic signed [13:0] r;
    if (v > EdgeW'(8191)) begin
      r = 14'sd8191;
    end else if (v < -EdgeW'(8192)) begin
      r = -14'sd8192;
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  // saturate a box size to [0, 16383]
  function automatic logic [13:0] sat_size(logic signed [EdgeW:0] v);
    logic [13:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > (EdgeW + 1)'(16383)) begin
      r = 14'd16383;
    end else begin
      r = v[13:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [15:0] thr_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == egbd_pkg::RegScoreThreshold);
  assign prdata = (paddr[2:2] == egbd_pkg::RegScoreThreshold) ? 32'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= egbd_pkg::ThresholdRst;
    end else if (cfg_wr) begin
      thr_q <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;
  logic          cell_pass;

  always_comb begin
    adv[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[StOut];

  // threshold and map bounds decide if a request makes a result
  assign cell_pass = (score_i >= thr_q) && (32'(col_i) < egbd_pkg::MapWidth) &&
                     (32'(row_i) < egbd_pkg::MapHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i && cell_pass;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: input register, edge sums
  // ---------------------------------------------------------------------------
  egbd_pkg::cell_t cell_in_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cell_in_q.col      <= col_i;
      cell_in_q.row      <= row_i;
      cell_in_q.score    <= score_i;
      cell_in_q.d_right  <= dist_right_i;
      cell_in_q.d_bottom <= dist_bottom_i;
      cell_in_q.h        <= 17'(dist_top_i) + 17'(dist_bottom_i);
      cell_in_q.w        <= 17'(dist_right_i) + 17'(dist_left_i);
      cell_in_q.ang      <= angle_rad_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 1 to 4: rotation, four iterations each
  // ---------------------------------------------------------------------------
  egbd_pkg::rot_t  rot_init;
  logic            neg_init;
  egbd_pkg::rot_t  rot_q  [CS];
  egbd_pkg::cell_t cell_q [CS];
  logic            neg_q  [CS];

  // fold the angle into [-pi/2, pi/2] and start from the gain-scaled unit vector
  always_comb begin
    rot_init.x = egbd_pkg::CordicGainQ14;
    rot_init.y = '0;
    rot_init.z = ZW'(cell_in_q.ang) <<< 3;
    neg_init   = 1'b0;
    if (rot_init.z > egbd_pkg::HalfPiQ16) begin
      rot_init.z = rot_init.z - egbd_pkg::PiQ16;
      neg_init   = 1'b1;
    end else if (rot_init.z < -egbd_pkg::HalfPiQ16) begin
      rot_init.z = rot_init.z + egbd_pkg::PiQ16;
      neg_init   = 1'b1;
    end
  end

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    egbd_pkg::rot_t  rot_src;
    egbd_pkg::cell_t cell_src;
    logic            neg_src;
    egbd_pkg::rot_t  rot_d;

    if (k == 0) begin : g_first
      assign rot_src  = rot_init;
      assign cell_src = cell_in_q;
      assign neg_src  = neg_init;
    end else begin : g_next
      assign rot_src  = rot_q[k-1];
      assign cell_src = cell_q[k-1];
      assign neg_src  = neg_q[k-1];
    end

    // four micro-rotations, then undo the fold after the last stage
    always_comb begin
      rot_d = rot_src;
      for (int j = 0; j < int'(egbd_pkg::IterPerStage); j++) begin
        rot_d = cordic_iter(rot_d, 4'(k * int'(egbd_pkg::IterPerStage) + j));
      end
      if ((k == CS - 1) && neg_src) begin
        rot_d.x = -rot_d.x;
        rot_d.y = -rot_d.y;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+1]) begin
        rot_q[k]  <= rot_d;
        cell_q[k] <= cell_src;
        neg_q[k]  <= neg_src;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: products of cos/sin with distances, angle scaling
  // ---------------------------------------------------------------------------
  logic signed [XyW-1:0]  cos_v;
  logic signed [XyW-1:0]  sin_v;
  logic signed [16:0]     dr_s;
  logic signed [16:0]     db_s;
  logic signed [17:0]     h_s;
  logic signed [17:0]     w_s;
  logic signed [16:0]     nang;
  logic signed [AccW-1:0] p_cdr_q, p_sdb_q, p_sh_q, p_cw_q;
  logic signed [AccW-1:0] p_sdr_q, p_cdb_q, p_sw_q, p_ch_q;
  logic signed [DegW-1:0] p_deg_q;
  egbd_pkg::cell_t        cell_m_q;

  assign cos_v = rot_q[CS-1].x;
  assign sin_v = rot_q[CS-1].y;
  assign dr_s  = $signed({1'b0, cell_q[CS-1].d_right});
  assign db_s  = $signed({1'b0, cell_q[CS-1].d_bottom});
  assign h_s   = $signed({1'b0, cell_q[CS-1].h});
  assign w_s   = $signed({1'b0, cell_q[CS-1].w});
  assign nang  = -(17'(cell_q[CS-1].ang));

  always_ff @(posedge clk_i) begin
    if (adv[StMul]) begin
      p_cdr_q  <= AccW'(cos_v * dr_s);
      p_sdb_q  <= AccW'(sin_v * db_s);
      p_sh_q   <= AccW'(sin_v * h_s);
      p_cw_q   <= AccW'(cos_v * w_s);
      p_sdr_q  <= AccW'(sin_v * dr_s);
      p_cdb_q  <= AccW'(cos_v * db_s);
      p_sw_q   <= AccW'(sin_v * w_s);
      p_ch_q   <= AccW'(cos_v * h_s);
      p_deg_q  <= DegW'(nang * $signed({1'b0, egbd_pkg::DegScaleQ16}));
      cell_m_q <= cell_q[CS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: box centre in Q.19 pixels, rounded degrees
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0] cx_d, cy_d, cx_q, cy_q;
  logic signed [DegW-1:0] deg_full;
  logic signed [15:0]     deg_d, deg_q;
  logic [16:0]            h_q, w_q;
  logic [15:0]            score_s_q;

  always_comb begin
    cx_d = (((AccW'(cell_m_q.col) <<< 20) + p_cdr_q + p_sdb_q) <<< 1) - p_sh_q - p_cw_q;
    cy_d = (((AccW'(cell_m_q.row) <<< 20) - p_sdr_q + p_cdb_q) <<< 1) + p_sw_q - p_ch_q;
    deg_full = (p_deg_q + DegW'(32768)) >>> 16;
    if (deg_full > DegW'(32767)) begin
      deg_d = 16'sh7fff;
    end else if (deg_full < -DegW'(32768)) begin
      deg_d = -16'sh8000;
    end else begin
      deg_d = deg_full[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[StSum]) begin
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      deg_q     <= deg_d;
      h_q       <= cell_m_q.h;
      w_q       <= cell_m_q.w;
      score_s_q <= cell_m_q.score;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: edges, floor/ceil to pixels, saturation, output register
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0]  half_w, half_h;
  logic signed [AccW-1:0]  left, right, top, bottom;
  logic signed [EdgeW-1:0] fl, fr, ft, fb;
  logic signed [EdgeW:0]   width_raw, height_raw;

  always_comb begin
    half_w = AccW'({w_q, 14'b0});
    half_h = AccW'({h_q, 14'b0});
    left   = cx_q - half_w;
    right  = cx_q + half_w;
    top    = cy_q - half_h;
    bottom = cy_q + half_h;
    fl     = EdgeW'(left >>> 19);
    ft     = EdgeW'(top >>> 19);
    fr     = EdgeW'((right + $signed(AccW'(19'h7ffff))) >>> 19);
    fb     = EdgeW'((bottom + $signed(AccW'(19'h7ffff))) >>> 19);
    width_raw  = (EdgeW + 1)'(fr) - (EdgeW + 1)'(fl) + (EdgeW + 1)'(1);
    height_raw = (EdgeW + 1)'(fb) - (EdgeW + 1)'(ft) + (EdgeW + 1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv[StOut]) begin
      box_x_o      <= sat_coord(fl);
      box_y_o      <= sat_coord(ft);
      box_width_o  <= sat_size(width_raw);
      box_height_o <= sat_size(height_raw);
      angle_deg_o  <= deg_q;
      score_out_o  <= score_s_q;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_east_geometry_box_decode.sv
// ----------------------------------------------------------------------------
// tb_east_geometry_box_decode
// Self-checking bench for the text box geometry decoder. A short table of
// directed cells comes first, then bursts of random cells under several score
// thresholds. Random cells and most table rows run through an in-bench fixed-point
// model (rotation, centre, floor/ceil bounding, degree scaling), and every returned
// box is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb_east_geometry_box_decode;
  import egbd_pkg::*;

  localparam int unsigned ClkHalf      = 5;
  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned SettleCycles = 12;   // pipeline depth plus margin
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned PhaseCells   = 255;
  localparam int unsigned PhaseBoxes   = 40;

  // register byte addresses
  localparam logic [2:0] AddrThreshold = {RegScoreThreshold, 2'b00};
  localparam logic [2:0] AddrSpare     = 3'd4;  // word one, no register behind it

  typedef struct {
    logic [7:0]         col;
    logic [7:0]         row;
    logic [15:0]        score;
    logic [15:0]        d_top;
    logic [15:0]        d_right;
    logic [15:0]        d_bottom;
    logic [15:0]        d_left;
    logic signed [15:0] ang;
  } cell_req_t;

  typedef struct {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [13:0]        width;
    logic [13:0]        height;
    logic signed [15:0] deg;
    logic [15:0]        score;
  } box_t;

  typedef enum logic [1:0] {CheckModel, CheckDropped, CheckFixed} row_check_e;

  typedef struct {
    cell_req_t  req;
    row_check_e check;
    box_t       box;
  } table_row_t;

  typedef enum logic [2:0] {
    SinkOpen, SinkMostly, SinkSparse, SinkPeriodic, SinkBlocks
  } sink_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [7:0]         col_i         = '0;
  logic [7:0]         row_i         = '0;
  logic [15:0]        score_i       = '0;
  logic [15:0]        dist_top_i    = '0;
  logic [15:0]        dist_right_i  = '0;
  logic [15:0]        dist_bottom_i = '0;
  logic [15:0]        dist_left_i   = '0;
  logic signed [15:0] angle_rad_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [13:0] box_x_o;
  logic signed [13:0] box_y_o;
  logic [13:0]        box_width_o;
  logic [13:0]        box_height_o;
  logic signed [15:0] angle_deg_o;
  logic [15:0]        score_out_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [2:0]         paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  // bench copy of the threshold register
  logic [15:0] threshold = ThresholdRst;
  box_t        pending_boxes[$];
  int unsigned boxes_seen  = 0;
  int unsigned faults      = 0;
  int unsigned idle_cycles = 0;

  sink_mode_e  sink_mode = SinkOpen;
  int unsigned sink_left = 0;
  logic [7:0]  sink_tick = '0;

  east_geometry_box_decode DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .col_i         (col_i),
    .row_i         (row_i),
    .score_i       (score_i),
    .dist_top_i    (dist_top_i),
    .dist_right_i  (dist_right_i),
    .dist_bottom_i (dist_bottom_i),
    .dist_left_i   (dist_left_i),
    .angle_rad_i   (angle_rad_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .box_x_o       (box_x_o),
    .box_y_o       (box_y_o),
    .box_width_o   (box_width_o),
    .box_height_o  (box_height_o),
    .angle_deg_o   (angle_deg_o),
    .score_out_o   (score_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // expected box for one cell, zero when the cell is dropped
  function automatic bit decode_box(input cell_req_t c, input logic [15:0] thr,
                                    output box_t b);
    longint ang, z, x, y, dx, dy, cs, sn;
    longint h, w, dr, db, cx, cy, lft, rgt, top, bot;
    longint fl, fr, ft, fb, deg;
    bit flip;
    b = '{default: '0};
    if (c.score < thr || c.col >= MapWidth || c.row >= MapHeight) return 1'b0;

    // fold the angle into the right half plane
    ang  = c.ang;
    z    = ang * 8;
    flip = 1'b0;
    if (z > longint'(HalfPiQ16)) begin
      z    = z - longint'(PiQ16);
      flip = 1'b1;
    end else if (z < -longint'(HalfPiQ16)) begin
      z    = z + longint'(PiQ16);
      flip = 1'b1;
    end

    // rotation iterations, floor shifts
    x = longint'(CordicGainQ14);
    y = 0;
    for (int i = 0; i < CordicIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(AtanQ16[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(AtanQ16[i]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;

    // centre and edges in Q.19 pixels
    h   = longint'(c.d_top) + longint'(c.d_bottom);
    w   = longint'(c.d_right) + longint'(c.d_left);
    dr  = longint'(c.d_right);
    db  = longint'(c.d_bottom);
    cx  = 2 * ((longint'(c.col) <<< 20) + cs * dr + sn * db) - sn * h - cs * w;
    cy  = 2 * ((longint'(c.row) <<< 20) - sn * dr + cs * db) + sn * w - cs * h;
    lft = cx - w * 16384;
    rgt = cx + w * 16384;
    top = cy - h * 16384;
    bot = cy + h * 16384;
    fl  = lft >>> 19;
    fr  = -((-rgt) >>> 19);
    ft  = top >>> 19;
    fb  = -((-bot) >>> 19);

    deg = clamp((-ang * longint'(DegScaleQ16) + 32768) >>> 16, -32768, 32767);

    b.x      = 14'(clamp(fl, -8192, 8191));
    b.y      = 14'(clamp(ft, -8192, 8191));
    b.width  = 14'(clamp(fr - fl + 1, 0, 16383));
    b.height = 14'(clamp(fb - ft + 1, 0, 16383));
    b.deg    = 16'(deg);
    b.score  = c.score;
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'($urandom);
      4:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    logic signed [15:0] a;
    case ($urandom_range(0, 9))
      0:       a = '0;
      1:       a = 16'sh8000;
      2:       a = 16'sh7fff;
      3, 4:    a = 16'(12867 + $urandom_range(0, 2));   // around a quarter turn
      default: a = 16'($urandom);
    endcase
    if ($urandom_range(0, 1) != 0 && a != 16'sh8000) a = -a;
    return a;
  endfunction

  // scores cluster at the threshold and the ends of the range
  function automatic cell_req_t random_cell(input logic [15:0] thr);
    cell_req_t c;
    c.col = 8'($urandom);
    c.row = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       c.score = '0;
      1, 2:    c.score = '1;
      3, 4, 5: c.score = 16'(thr + $urandom_range(0, 4) - 2);
      default: c.score = 16'($urandom);
    endcase
    c.d_top    = rand_dist();
    c.d_right  = rand_dist();
    c.d_bottom = rand_dist();
    c.d_left   = rand_dist();
    c.ang      = rand_angle();
    return c;
  endfunction

  // drive one cell request and record what it should produce
  task automatic send_cell(input table_row_t r);
    box_t b;
    in_valid_i    <= 1'b1;
    col_i         <= r.req.col;
    row_i         <= r.req.row;
    score_i       <= r.req.score;
    dist_top_i    <= r.req.d_top;
    dist_right_i  <= r.req.d_right;
    dist_bottom_i <= r.req.d_bottom;
    dist_left_i   <= r.req.d_left;
    angle_rad_i   <= r.req.ang;
    do @(posedge clk_i); while (!in_ready_o);
    case (r.check)
      CheckFixed: pending_boxes.push_back(r.box);
      CheckModel: if (decode_box(r.req, threshold, b)) pending_boxes.push_back(b);
      default: ;
    endcase
  endtask

  // wait for the pipeline to drain, including dropped cells still in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrThreshold) threshold = data[15:0];
    @(posedge clk_i);
  endtask

  // random bursts with gaps; after PhaseCells cells, stops once enough boxes came back, capped at 4 * PhaseCells cells
  task automatic run_phase();
    table_row_t  r;
    int unsigned burst;
    int unsigned first_box;
    burst     = 0;
    first_box = boxes_seen;
    r.check   = CheckModel;
    r.box     = '{default: '0};
    for (int unsigned k = 0; k < 4 * PhaseCells; k++) begin
      if (k >= PhaseCells && boxes_seen - first_box >= PhaseBoxes) break;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      r.req = random_cell(threshold);
      send_cell(r);
      burst--;
    end
    settle();
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      faults++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // receiver ready pattern, switching to a random mode whenever sink_left runs out
  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 8'd1;
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 4));
      sink_left <= $urandom_range(32, 256);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SinkOpen:     out_ready_i <= 1'b1;
      SinkMostly:   out_ready_i <= ($urandom_range(0, 3) != 0);
      SinkSparse:   out_ready_i <= ($urandom_range(0, 3) == 0);
      SinkPeriodic: out_ready_i <= (sink_tick[2:0] > 3'd2);
      default:      out_ready_i <= sink_tick[4];
    endcase
  end

  // box checker
  always @(posedge clk_i) begin : check_boxes
    box_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      boxes_seen++;
      if (pending_boxes.size() == 0) begin
        faults++;
        $display("%0t: box mismatch, expected none, actual x %0d y %0d w %0d h %0d",
                 $time, box_x_o, box_y_o, box_width_o, box_height_o);
      end else begin
        want = pending_boxes.pop_front();
        check_field("box_x", want.x, box_x_o);
        check_field("box_y", want.y, box_y_o);
        check_field("box_width", want.width, box_width_o);
        check_field("box_height", want.height, box_height_o);
        check_field("angle_deg", want.deg, angle_deg_o);
        check_field("score_out", want.score, score_out_o);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    table_row_t rows[$];
    box_t       no_box;
    no_box = '{default: '0};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // score equal to the threshold passes; zero distances give a point box
    rows.push_back('{'{0, 0, 32768, 0, 0, 0, 0, 0}, CheckFixed,
                     '{0, 0, 1, 1, 0, 32768}});
    // just below the threshold, and zero score
    rows.push_back('{'{0, 0, 32767, 0, 0, 0, 0, 0}, CheckDropped, no_box});
    rows.push_back('{'{17, 3, 0, 16, 16, 16, 16, 0}, CheckDropped, no_box});
    // last column of the map: far corner at full score, then row zero
    rows.push_back('{'{255, 255, 65535, 0, 0, 0, 0, 0}, CheckFixed,
                     '{1020, 1020, 1, 1, 0, 65535}});
    rows.push_back('{'{255, 0, 40000, 0, 0, 0, 0, 0}, CheckFixed,
                     '{1020, 0, 1, 1, 0, 40000}});
    // degree scaling alone: one radian and the most negative angle
    rows.push_back('{'{0, 0, 50000, 0, 0, 0, 0, 8192}, CheckFixed,
                     '{0, 0, 1, 1, -7334, 50000}});
    rows.push_back('{'{5, 9, 65535, 0, 0, 0, 0, -32768}, CheckFixed,
                     '{20, 36, 1, 1, 29335, 65535}});
    // widest box, upright and at the angle extremes
    rows.push_back('{'{128, 128, 65535, 65535, 65535, 65535, 65535, 0}, CheckModel, no_box});
    rows.push_back('{'{128, 128, 65535, 65535, 65535, 65535, 65535, -32768},
                     CheckModel, no_box});
    rows.push_back('{'{128, 128, 65535, 65535, 65535, 65535, 65535, 32767},
                     CheckModel, no_box});
    // either side of a quarter turn, where the angle fold starts
    rows.push_back('{'{10, 20, 40000, 160, 320, 480, 640, 12868}, CheckModel, no_box});
    rows.push_back('{'{10, 20, 40000, 160, 320, 480, 640, 12869}, CheckModel, no_box});
    rows.push_back('{'{10, 20, 40000, 160, 320, 480, 640, -12868}, CheckModel, no_box});
    rows.push_back('{'{10, 20, 40000, 160, 320, 480, 640, -12869}, CheckModel, no_box});
    // edges pushed far past the map on either side, at an eighth turn
    rows.push_back('{'{0, 0, 50000, 65535, 0, 0, 65535, 6434}, CheckModel, no_box});
    rows.push_back('{'{255, 255, 50000, 0, 65535, 65535, 0, -6434}, CheckModel, no_box});
    // alternating bit patterns
    rows.push_back('{'{8'haa, 8'h55, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                       16'sh5555}, CheckModel, no_box});
    rows.push_back('{'{8'h55, 8'haa, 16'hd555, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                       16'shaaaa}, CheckModel, no_box});
    // one pixel each way, upright
    rows.push_back('{'{1, 2, 65535, 16, 16, 16, 16, 0}, CheckModel, no_box});

    foreach (rows[i]) send_cell(rows[i]);
    settle();

    run_phase();
    write_reg(AddrThreshold, {16'($urandom), 16'h0000});
    run_phase();
    write_reg(AddrThreshold, {16'($urandom), 16'hffff});
    run_phase();
    // nothing lives at the spare word, so the threshold must stay put
    write_reg(AddrSpare, {16'($urandom), 16'h0000});
    run_phase();
    write_reg(AddrThreshold, $urandom);
    run_phase();
    write_reg(AddrThreshold, {16'($urandom), 16'h0001});
    run_phase();

    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
